[src/terrain_grid_to_sphere_point_core_assert.svh]
// assertion macros for the terrain grid to sphere point core
// needs a clk and a rst signal in the scope where the macros are used
`ifndef TERRAIN_GRID_TO_SPHERE_POINT_CORE_ASSERT_SVH
`define TERRAIN_GRID_TO_SPHERE_POINT_CORE_ASSERT_SVH

// property checked only outside reset
`define TGSP_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define TGSP_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tgsp_pkg.sv]
// shared constants, register codes and the cordic angle table
// no dependencies
package tgsp_pkg;

  localparam int MAX_GRID_DEF = 4096;
  localparam int GS_W    = 13;
  localparam int ROW_W   = 12;
  localparam int H_W     = 16;
  localparam int LAT_W   = 30;
  localparam int LON_W   = 31;
  localparam int OUT_W   = 29;
  localparam int NUM_W   = 44;
  localparam int DEN_W   = 13;
  localparam int ANG_W   = 45;
  localparam int FX_W    = 34;
  localparam int RAD_W   = 29;
  localparam int RED_N   = 16;
  localparam int CORDIC_STEPS = 30;

  localparam longint PI_FX         = 843314857;
  localparam longint HALF_PI_FX    = 421657428;
  localparam longint TWO_PI_FX     = 1686629713;
  localparam longint QUARTER_PI_FX = 210828714;
  localparam longint CORDIC_K      = 652032874;
  localparam longint EARTH_FX      = 225700641;
  localparam longint M_PER_NM      = 1852;
  localparam longint VOID_HEIGHT   = -32768;

  typedef enum logic [2:0] {
    REG_LAT_LOW  = 3'd0,
    REG_LAT_HIGH = 3'd1,
    REG_LON_LOW  = 3'd2,
    REG_LON_HIGH = 3'd3,
    REG_GRID     = 3'd4
  } reg_idx_t;

  // atan(2^-i) at 2^-28, from the series at 2^-60
  function automatic longint atan_fx(input int i);
    longint acc;
    longint term;
    int     k;
    acc = 0;
    if (i == 0) return QUARTER_PI_FX;
    for (k = 1; i * k <= 60; k += 2) begin
      term = longint'((64'd1 << (60 - i * k)) / 64'(k));
      if ((k % 4) == 1) acc += term;
      else acc -= term;
    end
    return (acc + (64'sd1 <<< 31)) >>> 32;
  endfunction

endpackage

[src/tgsp_div.sv]
// pipelined restoring divider, one quotient bit per stage, several lanes
// uses nothing from the package
module tgsp_div #(
  parameter int NW    = 44,
  parameter int DW    = 13,
  parameter int LANES = 3,
  parameter int TW    = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num [LANES],
  input  logic [DW-1:0] in_den [LANES],
  input  logic [TW-1:0] in_tag,
  output logic          out_vld,
  output logic [NW-1:0] out_quo [LANES],
  output logic [TW-1:0] out_tag
);

  localparam int T = NW + 1;

  logic [T-1:0]  vld;
  logic [TW-1:0] tag_q [T];
  logic [NW-1:0] num_q [T][LANES];
  logic [NW-1:0] quo_q [T][LANES];
  logic [DW-1:0] rem_q [T][LANES];
  logic [DW-1:0] den_q [T][LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[T-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_q[0] <= in_tag;
      for (int t = 1; t < T; t++) tag_q[t] <= tag_q[t-1];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        num_q[0][l] <= in_num[l];
        den_q[0][l] <= in_den[l];
        quo_q[0][l] <= '0;
        rem_q[0][l] <= '0;
      end
    end

    for (genvar s = 0; s < NW; s++) begin : g_st
      logic [DW:0] trial;
      logic        fits;
      always_comb begin
        trial = {rem_q[s][l], num_q[s][l][NW-1]};
        fits  = trial >= {1'b0, den_q[s][l]};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          num_q[s+1][l] <= {num_q[s][l][NW-2:0], 1'b0};
          den_q[s+1][l] <= den_q[s][l];
          quo_q[s+1][l] <= {quo_q[s][l][NW-2:0], fits};
          rem_q[s+1][l] <= fits ? DW'(trial - {1'b0, den_q[s][l]}) : DW'(trial);
        end
      end
    end

    assign out_quo[l] = quo_q[T-1][l];
  end

  assign out_vld = vld[T-1];
  assign out_tag = tag_q[T-1];

endmodule

[src/tgsp_cordic.sv]
// pipelined angle reduction and 30 step rotation cordic, sine and cosine per lane
// uses tgsp_pkg for the angle constants and the atan table
module tgsp_cordic
  import tgsp_pkg::*;
#(
  parameter int LANES = 2,
  parameter int TW    = 29
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [ANG_W-1:0] in_ang [LANES],
  input  logic [TW-1:0]           in_tag,
  output logic                    out_vld,
  output logic signed [FX_W-1:0]  out_sin [LANES],
  output logic signed [FX_W-1:0]  out_cos [LANES],
  output logic [TW-1:0]           out_tag
);

  localparam int MW = ANG_W - 1;
  localparam int CW = MW + 3;
  localparam int T  = RED_N + CORDIC_STEPS + 4;

  logic [T-1:0]  vld;
  logic [TW-1:0] tag_q [T];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[T-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_q[0] <= in_tag;
      for (int t = 1; t < T; t++) tag_q[t] <= tag_q[t-1];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [MW-1:0]      m_q  [RED_N+1];
    logic               ng_q [RED_N+1];
    logic signed [31:0] r1_q;
    logic               n1_q;
    logic signed [FX_W-1:0] x_q [CORDIC_STEPS+1];
    logic signed [FX_W-1:0] y_q [CORDIC_STEPS+1];
    logic signed [31:0]     z_q [CORDIC_STEPS+1];
    logic                   f_q [CORDIC_STEPS+1];
    logic signed [FX_W-1:0] s_q, c_q;
    logic [30:0]        m31;
    logic signed [31:0] r0;

    // magnitude and sign
    always_ff @(posedge clk) begin
      if (en) begin
        ng_q[0] <= in_ang[l][ANG_W-1];
        m_q[0]  <= in_ang[l][ANG_W-1] ? MW'(-in_ang[l]) : MW'(in_ang[l]);
      end
    end

    // modulo two pi by conditional subtraction of shifted copies
    for (genvar j = 0; j < RED_N; j++) begin : g_red
      localparam longint CK = TWO_PI_FX <<< (RED_N - 1 - j);
      always_ff @(posedge clk) begin
        if (en) begin
          ng_q[j+1] <= ng_q[j];
          if (CW'(m_q[j]) >= CW'(CK)) m_q[j+1] <= MW'(CW'(m_q[j]) - CW'(CK));
          else m_q[j+1] <= m_q[j];
        end
      end
    end

    // back to the signed range around zero
    always_comb begin
      m31 = m_q[RED_N][30:0];
      if (ng_q[RED_N] && m31 != '0) r0 = 32'(TWO_PI_FX) - $signed({1'b0, m31});
      else r0 = $signed({1'b0, m31});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r1_q <= (r0 >= 32'(PI_FX)) ? r0 - 32'(TWO_PI_FX) : r0;
      end
    end

    // fold into the right half plane
    always_ff @(posedge clk) begin
      if (en) begin
        x_q[0] <= FX_W'(CORDIC_K);
        y_q[0] <= '0;
        if (r1_q > 32'(HALF_PI_FX)) begin
          z_q[0] <= r1_q - 32'(PI_FX);
          f_q[0] <= 1'b1;
        end else if (r1_q < -32'(HALF_PI_FX)) begin
          z_q[0] <= r1_q + 32'(PI_FX);
          f_q[0] <= 1'b1;
        end else begin
          z_q[0] <= r1_q;
          f_q[0] <= 1'b0;
        end
      end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      localparam longint AT = atan_fx(i);
      always_ff @(posedge clk) begin
        if (en) begin
          f_q[i+1] <= f_q[i];
          if (z_q[i] >= 0) begin
            x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
            y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
            z_q[i+1] <= z_q[i] - 32'(AT);
          end else begin
            x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
            y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
            z_q[i+1] <= z_q[i] + 32'(AT);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_q <= f_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];
        c_q <= f_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
      end
    end

    assign out_sin[l] = s_q;
    assign out_cos[l] = c_q;
  end

  assign out_vld = vld[T-1];
  assign out_tag = tag_q[T-1];

endmodule

[src/tgsp_proj.sv]
// two multiplier stages that scale the unit vectors by the radius
// uses tgsp_pkg for the widths
module tgsp_proj
  import tgsp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [RAD_W-1:0] rad,
  input  logic signed [FX_W-1:0]  sin_lat,
  input  logic signed [FX_W-1:0]  cos_lat,
  input  logic signed [FX_W-1:0]  sin_lon,
  input  logic signed [FX_W-1:0]  cos_lon,
  output logic                    out_vld,
  output logic signed [OUT_W-1:0] x_pos,
  output logic signed [OUT_W-1:0] y_pos,
  output logic signed [OUT_W-1:0] z_pos
);

  localparam longint RND = 64'sd1 <<< 29;

  logic                    vld1;
  logic signed [29:0]      rc_q;
  logic signed [OUT_W-1:0] y1_q;
  logic signed [FX_W-1:0]  slon_q, clon_q;
  logic signed [63:0]      p_rc, p_y, p_x, p_z;

  always_comb begin
    p_rc = 64'(rad) * 64'(cos_lat) + RND;
    p_y  = 64'(rad) * 64'(sin_lat) + RND;
    p_x  = 64'(rc_q) * 64'(clon_q) + RND;
    p_z  = 64'(rc_q) * 64'(slon_q) + RND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc_q   <= 30'(p_rc >>> 30);
      y1_q   <= OUT_W'(p_y >>> 30);
      slon_q <= sin_lon;
      clon_q <= cos_lon;
      x_pos  <= OUT_W'(p_x >>> 30);
      y_pos  <= y1_q;
      z_pos  <= OUT_W'(-(p_z >>> 30));
    end
  end

endmodule

[src/terrain_grid_to_sphere_point_core.sv]
// top level: register file, grid to angle front end, divider, cordic and projection
// uses tgsp_pkg, tgsp_div, tgsp_cordic and tgsp_proj
//
// Turns one terrain grid sample (row, col, height in metres) into a point on the
// sphere, x/y/z in nautical miles at 2^-16. One item is taken every clock cycle
// and one result comes out per item, in order. The pipe is built from
// three front end stages (the height over 1852 is done there by a reciprocal
// multiply), 45 stages of the pipelined divider that scales the bounds by row
// and column over grid_size-1, one stage to add the low bounds, 50 cordic stages
// (one for the magnitude, 16 for the reduction modulo two pi, two for folding,
// 30 rotations, one for the sign) and two multiplier stages. The whole pipe
// advances while the output register is empty or taken, so s_tready is low only
// while a finished item waits on m_tready. Bounds and grid_size are sampled live,
// so they must not be written while items are in flight. A void sample or a row
// or column at or past the grid size puts the point on the bare sphere.
module terrain_grid_to_sphere_point_core
  import tgsp_pkg::*;
#(
  parameter int MAX_GRID = MAX_GRID_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // item in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // row[11:0], col[23:12], height[39:24]
  // item out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // x_pos[28:0], y_pos[57:29], z_pos[86:58], zero pad
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // grid sizes above the limit count as the limit
  localparam int NCL = (MAX_GRID > (1 << GS_W) - 1) ? (1 << GS_W) - 1 : MAX_GRID;

  // height offset: 1852 = 4*463, so rnd(h*65536/1852) = (h*16384 + 231) / 463,
  // done as a multiply by the rounded up reciprocal, exact for 29 bit numerators
  localparam int     RQ_W     = 21;
  localparam int     RCP_SH   = 38;
  localparam longint NM_DIV4  = M_PER_NM / 4;
  localparam longint NM_RECIP = ((64'sd1 <<< RCP_SH) + NM_DIV4 - 1) / NM_DIV4;

  // configuration registers
  logic signed [LAT_W-1:0] lat_low, lat_high;
  logic signed [LON_W-1:0] lon_low, lon_high;
  logic [GS_W-1:0]         grid_size;
  logic                    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_low   <= '0;
      lat_high  <= '0;
      lon_low   <= '0;
      lon_high  <= '0;
      grid_size <= GS_W'(1201);
    end else if (wr_en) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_LAT_LOW:  lat_low   <= pwdata[LAT_W-1:0];
        REG_LAT_HIGH: lat_high  <= pwdata[LAT_W-1:0];
        REG_LON_LOW:  lon_low   <= pwdata[LON_W-1:0];
        REG_LON_HIGH: lon_high  <= pwdata[LON_W-1:0];
        REG_GRID:     grid_size <= pwdata[GS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_LAT_LOW:  prdata = {{(32-LAT_W){1'b0}}, lat_low};
      REG_LAT_HIGH: prdata = {{(32-LAT_W){1'b0}}, lat_high};
      REG_LON_LOW:  prdata = {{(32-LON_W){1'b0}}, lon_low};
      REG_LON_HIGH: prdata = {{(32-LON_W){1'b0}}, lon_high};
      REG_GRID:     prdata = {{(32-GS_W){1'b0}}, grid_size};
      default:      prdata = '0;
    endcase
  end

  // effective grid size and divisor
  logic [GS_W-1:0] n_eff, d_eff;
  always_comb begin
    n_eff = (grid_size > GS_W'(NCL)) ? GS_W'(NCL) : grid_size;
    d_eff = (n_eff >= GS_W'(2)) ? n_eff - GS_W'(1) : GS_W'(1);
  end

  // global advance: the pipe moves unless a finished item is held
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input fields
  logic [ROW_W-1:0]      in_row, in_col;
  logic signed [H_W-1:0] in_h, h_eff;
  assign in_row = s_tdata[11:0];
  assign in_col = s_tdata[23:12];
  assign in_h   = s_tdata[39:24];

  always_comb begin
    if (in_h == H_W'(VOID_HEIGHT) || {1'b0, in_row} >= n_eff || {1'b0, in_col} >= n_eff)
      h_eff = '0;
    else
      h_eff = in_h;
  end

  // stage a: spans and row offset
  logic                    vld_a;
  logic signed [31:0]      dlat_a;
  logic signed [32:0]      dlon_a;
  logic signed [14:0]      drow_a;
  logic [ROW_W-1:0]        col_a;
  logic signed [H_W-1:0]   h_a;

  always_ff @(posedge clk) begin
    if (en) begin
      dlat_a <= 32'(lat_high) - 32'(lat_low);
      dlon_a <= 33'(lon_high) - 33'(lon_low);
      drow_a <= $signed({2'b0, d_eff}) - $signed({3'b0, in_row});
      col_a  <= in_col;
      h_a    <= h_eff;
    end
  end

  // stage b: span times offset
  logic               vld_b;
  logic signed [ANG_W:0] plat_b, plon_b;
  logic signed [H_W-1:0] h_b;

  always_ff @(posedge clk) begin
    if (en) begin
      plat_b <= (ANG_W+1)'(dlat_a) * (ANG_W+1)'(drow_a);
      plon_b <= (ANG_W+1)'(dlon_a) * $signed((ANG_W+1)'(col_a));
      h_b    <= h_a;
    end
  end

  // stage c: magnitudes with the rounding half added, height offset magnitude
  logic             vld_c;
  logic [NUM_W-1:0] num_c [2];
  logic [DEN_W-1:0] den_c [2];
  logic [2:0]       neg_c;
  logic [RQ_W-1:0]  rq_c;
  logic [H_W-2:0]   hmag;
  logic [28:0]      hsc;
  logic [58:0]      hprod;

  always_comb begin
    hmag  = h_b[H_W-1] ? (H_W-1)'(-h_b) : (H_W-1)'(h_b);
    // h*16384 plus the rounding half of 1852, already divided by four
    hsc   = {hmag, 14'(M_PER_NM / 8)};
    hprod = hsc * 30'(NM_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_c    <= {h_b[H_W-1], plon_b[ANG_W], plat_b[ANG_W]};
      num_c[0] <= NUM_W'(plat_b[ANG_W] ? -plat_b : plat_b) + NUM_W'(d_eff >> 1);
      num_c[1] <= NUM_W'(plon_b[ANG_W] ? -plon_b : plon_b) + NUM_W'(d_eff >> 1);
      rq_c     <= RQ_W'(hprod >> RCP_SH);
    end
  end

  assign den_c[0] = d_eff;
  assign den_c[1] = d_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
    end else if (en) begin
      vld_a <= s_tvalid;
      vld_b <= vld_a;
      vld_c <= vld_b;
    end
  end

  // divider: lat and lon lanes, height offset and signs ride in the tag
  logic                  vld_q;
  logic [NUM_W-1:0]      quo [2];
  logic [RQ_W+2:0]       tag_q;
  logic [2:0]            neg_q;
  logic [RQ_W-1:0]       rq_q;

  tgsp_div #(
    .NW(NUM_W), .DW(DEN_W), .LANES(2), .TW(RQ_W + 3)
  ) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(vld_c), .in_num(num_c), .in_den(den_c), .in_tag({rq_c, neg_c}),
    .out_vld(vld_q), .out_quo(quo), .out_tag(tag_q)
  );

  assign neg_q = tag_q[2:0];
  assign rq_q  = tag_q[RQ_W+2:3];

  // stage d: add the low bounds and the earth radius
  logic                    vld_d;
  logic signed [ANG_W-1:0] ang_d [2];
  logic signed [RAD_W-1:0] rad_d;
  logic signed [ANG_W-1:0] qlat, qlon;
  logic signed [RAD_W-1:0] qrad;

  always_comb begin
    qlat = $signed({1'b0, quo[0]});
    qlon = $signed({1'b0, quo[1]});
    qrad = $signed({{(RAD_W-RQ_W){1'b0}}, rq_q});
  end

  always_ff @(posedge clk) begin
    if (rst) vld_d <= 1'b0;
    else if (en) vld_d <= vld_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_d[0] <= ANG_W'(lat_low) + (neg_q[0] ? -qlat : qlat);
      ang_d[1] <= ANG_W'(lon_low) + (neg_q[1] ? -qlon : qlon);
      rad_d    <= RAD_W'(EARTH_FX) + (neg_q[2] ? -qrad : qrad);
    end
  end

  // sine and cosine of both angles, radius rides along
  logic                    vld_k;
  logic signed [FX_W-1:0]  sn [2];
  logic signed [FX_W-1:0]  cs [2];
  logic [RAD_W-1:0]        rad_k;

  tgsp_cordic #(
    .LANES(2), .TW(RAD_W)
  ) u_cordic (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(vld_d), .in_ang(ang_d), .in_tag(rad_d),
    .out_vld(vld_k), .out_sin(sn), .out_cos(cs), .out_tag(rad_k)
  );

  // scale by the radius
  logic signed [OUT_W-1:0] x_pos, y_pos, z_pos;

  tgsp_proj u_proj (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(vld_k), .rad($signed(rad_k)),
    .sin_lat(sn[0]), .cos_lat(cs[0]), .sin_lon(sn[1]), .cos_lon(cs[1]),
    .out_vld(m_tvalid), .x_pos(x_pos), .y_pos(y_pos), .z_pos(z_pos)
  );

  assign m_tdata = {1'b0, z_pos, y_pos, x_pos};

endmodule

[src/tgsp_checker.sv]
// port level checks for the terrain grid to sphere point core, bound to the top
// uses the assertion macros header and tgsp_pkg for the register codes
`include "terrain_grid_to_sphere_point_core_assert.svh"

module tgsp_checker
  import tgsp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  localparam logic [4:0] GRID_ADDR = {REG_GRID, 2'b00};

  // a held result keeps its value
  `TGSP_ASSERT_RUN(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output item changed while stalled")

  // the input side is open whenever no result is held
  `TGSP_ASSERT_RUN(a_in_open, !m_tvalid |-> s_tready, "input stalled with empty output")

  // grid size reads back what was written
  `TGSP_ASSERT_RUN(a_grid_rd, psel && penable && pwrite && pready && paddr == GRID_ADDR |=> paddr != GRID_ADDR || prdata[12:0] == $past(pwdata[12:0]), "grid size readback mismatch")

  // reset empties the pipe
  `TGSP_ASSERT_ALL(a_rst_empty, rst |=> !m_tvalid, "output valid right after reset")

endmodule

bind terrain_grid_to_sphere_point_core tgsp_checker u_tgsp_checker (.*);
